/* rtl/core/dbbs_pkg.sv */
// Shared constants and types for the dirty block bitmap scanner.
`default_nettype none

package dbbs_pkg;

    // Default capacity in blocks, and bits per bitmap word (a power of two).
    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    // Fixed field widths of the request and result channels.
    localparam int OPCODE_W    = 2;
    localparam int BLOCK_NUM_W = 16;
    localparam int BLOCK_OUT_W = 12;

    // Request opcodes; the fourth code is a no-operation.
    typedef enum logic [OPCODE_W-1:0] {
        OP_MARK    = 2'd0,
        OP_RESTART = 2'd1,
        OP_NEXT    = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

endpackage : dbbs_pkg

`default_nettype wire

/* rtl/core/dirty_block_bitmap_scanner.sv */
// Top level of the dirty block bitmap scanner: control sequencer and bitmap memory.
//
// Requests arrive on a valid/ready channel (i_valid, o_ready) carrying an opcode and a
// block number; each request gives exactly one result on o_valid/i_ready.
// Mark sets one bit of the bitmap, restart moves the scan cursor to block 0, and next
// returns the lowest marked block at or above the cursor and moves the cursor past it.
// The bitmap lives in one RAM of ceil(NUM_BLOCKS/WORD_BITS) words, read one word per
// cycle with a registered read; a priority encoder picks the lowest set bit of a word.
// Restart, no-op and out-of-range marks give their result in the cycle after the
// transfer; a mark reads the word, then writes it back; a next reads words from the
// cursor's word upward until it finds a set bit or passes the last word.
// One request is in flight at a time.
// After reset the block sweeps the RAM clearing one word per cycle, with o_ready
// low.
// A result sits in an output register until taken; a new request is accepted only
// when that register is empty or being emptied in the same cycle, so a stalled
// receiver holds off the request side.
`default_nettype none

module dirty_block_bitmap_scanner
    import dbbs_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [OPCODE_W-1:0]    i_opcode,
    input  wire logic [BLOCK_NUM_W-1:0] i_block_number,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_found,
    output logic [BLOCK_OUT_W-1:0]      o_block_out,
    output logic                        o_out_of_range
);

    localparam int WB_LOG      = $clog2(WORD_BITS);
    localparam int STORE_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IW          = $clog2(STORE_WORDS + 1);
    localparam int CW          = $clog2(NUM_BLOCKS + 1);
    localparam int BNW         = (CW > BLOCK_NUM_W) ? CW : BLOCK_NUM_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK_WR,
        S_SCAN
    } t_state;

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_first, n_first;
    logic [WB_LOG-1:0]      r_off, n_off;
    logic [CW-1:0]          r_cursor, n_cursor;
    logic                   r_out_valid, n_out_valid;
    logic                   r_found, n_found;
    logic [BLOCK_OUT_W-1:0] r_block_out, n_block_out;
    logic                   r_oor, n_oor;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [WORD_BITS-1:0]   mem_rdata;

    logic                   in_xfer;
    t_opcode                op;
    logic [BNW-1:0]         bn_ext;
    logic                   bn_oor;
    logic [WORD_BITS-1:0]   scan_word;
    logic                   enc_any;
    logic [WB_LOG-1:0]      enc_pos;
    logic [CW-1:0]          hit_block;
    logic [IW-1:0]          idx_inc;

    // Bitmap storage.
    dbbs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The first word of a scan is masked below the cursor offset.
    assign scan_word = r_first ? (mem_rdata & ({WORD_BITS{1'b1}} << r_off)) : mem_rdata;

    dbbs_prienc #(
        .WIDTH (WORD_BITS)
    ) u_prienc (
        .i_word (scan_word),
        .o_any  (enc_any),
        .o_pos  (enc_pos)
    );

    // Request decode and the block number of a hit.
    assign o_ready   = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_xfer   = i_valid && o_ready;
    assign op        = t_opcode'(i_opcode);
    assign bn_ext    = BNW'(i_block_number);
    assign bn_oor    = bn_ext >= BNW'(NUM_BLOCKS);
    assign hit_block = (CW'(r_idx) << WB_LOG) | CW'(enc_pos);
    assign idx_inc   = r_idx + IW'(1);

    // Next-state, memory access and result logic.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_first     = r_first;
        n_off       = r_off;
        n_cursor    = r_cursor;
        n_out_valid = r_out_valid && !i_ready;
        n_found     = r_found;
        n_block_out = r_block_out;
        n_oor       = r_oor;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_idx);
        mem_wdata   = '0;
        mem_raddr   = AW'(r_idx);

        case (r_state)
            S_CLEAR: begin
                // Sweep the RAM with zeros after reset.
                mem_we = 1'b1;
                if (r_idx == IW'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    case (op)
                        OP_MARK: begin
                            if (bn_oor) begin
                                n_out_valid = 1'b1;
                                n_found     = 1'b0;
                                n_block_out = '0;
                                n_oor       = 1'b1;
                            end else begin
                                // Read the word now, set the bit next cycle.
                                mem_raddr = AW'(bn_ext >> WB_LOG);
                                n_idx     = IW'(bn_ext >> WB_LOG);
                                n_off     = i_block_number[WB_LOG-1:0];
                                n_state   = S_MARK_WR;
                            end
                        end
                        OP_NEXT: begin
                            if (r_cursor >= CW'(NUM_BLOCKS)) begin
                                n_out_valid = 1'b1;
                                n_found     = 1'b0;
                                n_block_out = '0;
                                n_oor       = 1'b0;
                            end else begin
                                mem_raddr = AW'(r_cursor >> WB_LOG);
                                n_idx     = IW'(r_cursor >> WB_LOG);
                                n_off     = r_cursor[WB_LOG-1:0];
                                n_first   = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_RESTART: begin
                            n_cursor    = '0;
                            n_out_valid = 1'b1;
                            n_found     = 1'b0;
                            n_block_out = '0;
                            n_oor       = 1'b0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_found     = 1'b0;
                            n_block_out = '0;
                            n_oor       = 1'b0;
                        end
                    endcase
                end
            end
            S_MARK_WR: begin
                // Write back the word with the block's bit set.
                mem_we      = 1'b1;
                mem_wdata   = mem_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << r_off);
                n_out_valid = 1'b1;
                n_found     = 1'b0;
                n_block_out = '0;
                n_oor       = 1'b0;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                // Examine one word per cycle; the following word is read meanwhile.
                mem_raddr = AW'(idx_inc);
                n_first   = 1'b0;
                if (enc_any) begin
                    n_cursor    = hit_block + CW'(1);
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_block_out = BLOCK_OUT_W'(hit_block);
                    n_oor       = 1'b0;
                    n_state     = S_IDLE;
                end else if (idx_inc >= IW'(STORE_WORDS)) begin
                    n_cursor    = CW'(NUM_BLOCKS);
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_block_out = '0;
                    n_oor       = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_first     <= 1'b0;
            r_off       <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_block_out <= '0;
            r_oor       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_first     <= n_first;
            r_off       <= n_off;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_block_out <= n_block_out;
            r_oor       <= n_oor;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_block_out    = r_block_out;
    assign o_out_of_range = r_oor;

endmodule : dirty_block_bitmap_scanner

`default_nettype wire

/* rtl/core/dbbs_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module dbbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : dbbs_ram

`default_nettype wire

/* rtl/core/dbbs_prienc.sv */
// Priority encoder: position of the lowest set bit of one bitmap word.
`default_nettype none

module dbbs_prienc #(
    parameter int WIDTH = 64
) (
    input  wire logic [WIDTH-1:0]         i_word,
    output logic                          o_any,
    output logic [$clog2(WIDTH)-1:0]      o_pos
);

    localparam int PW = $clog2(WIDTH);

    // Walk from the top down so that the lowest set bit wins.
    always_comb begin
        o_pos = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_pos = PW'(i);
            end
        end
        o_any = |i_word;
    end

endmodule : dbbs_prienc

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the dirty block bitmap scanner.
`timescale 1ns / 1ps

module tb_top;
    import dbbs_pkg::*;

    localparam int NUM_BLOCKS   = NUM_BLOCKS_DEF;
    localparam int WORD_BITS    = WORD_BITS_DEF;
    localparam int NUM_WORDS    = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = NUM_WORDS + 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 400;
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 800;

    typedef struct packed {
        t_opcode                op;
        logic [BLOCK_NUM_W-1:0] bn;
    } t_request_s;

    typedef struct packed {
        logic                   found;
        logic [BLOCK_OUT_W-1:0] blk;
        logic                   oor;
    } t_result_s;

    // Block ports; the inputs are at known values from time zero.
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic [OPCODE_W-1:0]    i_opcode       = OP_NOP;
    logic [BLOCK_NUM_W-1:0] i_block_number = '0;
    logic                   i_ready        = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic                   o_found;
    logic [BLOCK_OUT_W-1:0] o_block_out;
    logic                   o_out_of_range;

    dirty_block_bitmap_scanner uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_block_number (i_block_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_block_out    (o_block_out),
        .o_out_of_range (o_out_of_range)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and prediction state.
    t_request_s       request_queue[$];
    t_result_s        pending_results[$];
    t_request_s       drive_req;
    logic [NUM_BLOCKS-1:0] marked_map = '0;
    int unsigned      cursor_pos   = 0;
    int unsigned      mismatches   = 0;
    int unsigned      accepted_reqs = 0;
    int unsigned      idle_cycles  = 0;
    int unsigned      hold_left    = 0;
    bit               hold_done    = 1'b0;
    bit               req_accepted = 1'b0;
    bit               quiet;

    assign quiet = (accepted_reqs >= QUIET_FROM) && (accepted_reqs < QUIET_TO);

    // Applies one request to the predicted bitmap and cursor, returning its result.
    function automatic t_result_s apply_request(t_request_s rq);
        t_result_s res;
        int unsigned b;
        res = '0;
        case (rq.op)
            OP_MARK: begin
                if (rq.bn >= NUM_BLOCKS)
                    res.oor = 1'b1;
                else
                    marked_map[rq.bn] = 1'b1;
            end
            OP_RESTART: begin
                cursor_pos = 0;
            end
            OP_NEXT: begin
                b = cursor_pos;
                while (b < NUM_BLOCKS && !marked_map[b])
                    b++;
                if (b < NUM_BLOCKS) begin
                    res.found = 1'b1;
                    res.blk   = b[BLOCK_OUT_W-1:0];
                    cursor_pos = b + 1;
                end else begin
                    cursor_pos = NUM_BLOCKS;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic queue_request(t_opcode op, int bn);
        t_request_s rq;
        rq.op = op;
        rq.bn = bn[BLOCK_NUM_W-1:0];
        request_queue.push_back(rq);
    endtask

    // Picks a block to mark: mostly inside a busy word, sometimes anywhere,
    // at a word edge, or beyond the capacity.
    function automatic int pick_mark_block(int hot_word);
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return hot_word * WORD_BITS + $urandom_range(WORD_BITS - 1);
        else if (sel < 80)
            return $urandom_range(NUM_BLOCKS - 1);
        else if (sel < 90)
            return $urandom_range(NUM_WORDS - 1) * WORD_BITS
                   + ($urandom_range(1) ? WORD_BITS - 1 : 0);
        else
            return $urandom_range(65535, NUM_BLOCKS);
    endfunction

    // Sender: offers the next queued request at the falling edge, holding it
    // until the transfer has taken place.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_accepted) begin
            req_accepted = 1'b0;
            if (request_queue.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
                drive_req = request_queue.pop_front();
                i_valid        <= 1'b1;
                i_opcode       <= drive_req.op;
                i_block_number <= drive_req.bn;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the block backs up.
    always @(negedge i_clk) begin
        if (!hold_done && accepted_reqs >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    // Monitor: checks each result transfer against the oldest prediction,
    // then predicts the result of any request transfer, and watches for hangs.
    always @(posedge i_clk) begin
        t_result_s want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_found !== want.found)
                        report_mismatch("found", o_found, want.found);
                    if (o_block_out !== want.blk)
                        report_mismatch("block_out", o_block_out, want.blk);
                    if (o_out_of_range !== want.oor)
                        report_mismatch("out_of_range", o_out_of_range, want.oor);
                end
            end
            if (i_valid && o_ready) begin
                pending_results.push_back(apply_request(t_request_s'({t_opcode'(i_opcode),
                                                                      i_block_number})));
                accepted_reqs++;
                req_accepted = 1'b1;
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus: directed cases first, then random rounds of marks and scans.
    initial begin
        int random_count;
        int hot_word;
        int marks;
        int scans;
        int roll;

        // Directed: empty bitmap, capacity and word edges, repeats, no-ops,
        // marks below and above the cursor, exhaustion and rescan.
        queue_request(OP_NEXT, 0);
        queue_request(OP_MARK, 0);
        queue_request(OP_MARK, NUM_BLOCKS - 1);
        queue_request(OP_MARK, NUM_BLOCKS);
        queue_request(OP_MARK, 65535);
        queue_request(OP_MARK, WORD_BITS - 1);
        queue_request(OP_MARK, WORD_BITS);
        queue_request(OP_MARK, WORD_BITS - 1);
        queue_request(OP_NOP, 65535);
        queue_request(OP_NOP, 0);
        queue_request(OP_RESTART, 65535);
        queue_request(OP_NEXT, 65535);
        queue_request(OP_NEXT, 0);
        queue_request(OP_MARK, 10);
        queue_request(OP_MARK, 2000);
        queue_request(OP_NEXT, 0);
        queue_request(OP_NEXT, 0);
        queue_request(OP_NEXT, 0);
        queue_request(OP_NEXT, 0);
        queue_request(OP_NEXT, 0);
        queue_request(OP_RESTART, 0);
        queue_request(OP_NEXT, 0);
        queue_request(OP_NEXT, 0);

        // Random rounds: a burst of marks, usually a restart, then a run of
        // next requests with stray marks, restarts and no-ops mixed in.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            hot_word = ($urandom_range(3) == 0) ? $urandom_range(NUM_WORDS - 1, NUM_WORDS - 4)
                                                : $urandom_range(NUM_WORDS - 1);
            marks = $urandom_range(12, 1);
            scans = $urandom_range(40, 1);
            repeat (marks)
                queue_request(OP_MARK, pick_mark_block(hot_word));
            random_count += marks;
            if ($urandom_range(99) < 60) begin
                queue_request(OP_RESTART, $urandom_range(65535));
                random_count++;
            end
            repeat (scans) begin
                roll = $urandom_range(99);
                if (roll < 15)
                    queue_request(OP_MARK, pick_mark_block(hot_word));
                else if (roll < 19)
                    queue_request(OP_NOP, $urandom_range(65535));
                else if (roll < 22)
                    queue_request(OP_RESTART, $urandom_range(65535));
                else
                    queue_request(OP_NEXT, $urandom_range(65535));
            end
            random_count += scans;
        end

        // Hold reset, then release it at a falling edge.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come out.
        while (request_queue.size() > 0 || i_valid || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
